>>> hdl/rrlp_pkg.sv
// Shared constants, types and helper functions of the read-response latency policy.
`timescale 1ns / 1ps
`default_nettype none

package rrlp_pkg;

  localparam int unsigned LATENCY_BITS = 32;
  localparam int unsigned COUNT_BITS   = 32;

  localparam int unsigned LAT_W      = LATENCY_BITS;
  localparam int unsigned DLY_W      = LATENCY_BITS + 1;
  localparam int unsigned STAT_W     = 32;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned SRC_W      = 24;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned FVC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned REASON_W   = 2;

  localparam logic [HASH_W-1:0] GOLDEN_ADD = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] MUL_ONE    = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MUL_TWO    = 64'h94d049bb133111eb;
  localparam logic [HASH_W-1:0] DRAW_LANE  = 64'h6a09e667f3bcc909;
  localparam logic [HASH_W-1:0] SEED_RESET = 64'h1;

  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 3'd5;

  // Reason codes of a response word.
  localparam logic [REASON_W-1:0] REASON_DISABLED = 2'd0;
  localparam logic [REASON_W-1:0] REASON_WITHIN   = 2'd1;
  localparam logic [REASON_W-1:0] REASON_OVER     = 2'd2;
  localparam logic [REASON_W-1:0] REASON_FAULT    = 2'd3;

  typedef struct packed {
    logic              enable;
    logic [LAT_W-1:0]  threshold;
    logic [LAT_W-1:0]  latency;
    logic [LAT_W-1:0]  jitter_span;
    logic [FVC_W-1:0]  forced_void;
    logic [HASH_W-1:0] seed;
  } cfg_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  // Golden-ratio add and the first xor-shift of the finaliser.
  function automatic logic [HASH_W-1:0] premix(input logic [HASH_W-1:0] key,
                                               input logic [HASH_W-1:0] word);
    logic [HASH_W-1:0] x;
    x = (key ^ word) + GOLDEN_ADD;
    return x ^ (x >> SHIFT_A);
  endfunction

endpackage

`default_nettype wire

>>> hdl/rrlp_ifs.sv
// Handshake channels of the policy block: request, response and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface rrlp_req_if;
  logic                         valid;
  logic                         ready;
  logic [rrlp_pkg::SRC_W-1:0]   source_id;
  logic [rrlp_pkg::TAG_W-1:0]   request_tag;
  logic [rrlp_pkg::ADDR_W-1:0]  remote_addr;
  logic [rrlp_pkg::LEN_W-1:0]   read_length;

  modport source (output valid, source_id, request_tag, remote_addr, read_length,
                  input ready);
  modport sink (input valid, source_id, request_tag, remote_addr, read_length,
                output ready);
endinterface

interface rrlp_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               send_null_reply;
  logic                               fault_forced;
  logic [rrlp_pkg::REASON_W-1:0]      reason_code;
  logic signed [rrlp_pkg::DLY_W-1:0]  jitter_value;
  logic [rrlp_pkg::DLY_W-1:0]         completion_delay;
  logic [rrlp_pkg::STAT_W-1:0]        evaluated_total;
  logic [rrlp_pkg::STAT_W-1:0]        normal_total;
  logic [rrlp_pkg::STAT_W-1:0]        null_total;
  logic [rrlp_pkg::STAT_W-1:0]        fault_total;

  modport source (output valid, send_null_reply, fault_forced, reason_code, jitter_value,
                  completion_delay, evaluated_total, normal_total, null_total,
                  fault_total, input ready);
  modport sink (input valid, send_null_reply, fault_forced, reason_code, jitter_value,
                completion_delay, evaluated_total, normal_total, null_total,
                fault_total, output ready);
endinterface

interface rrlp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rrlp_pkg::CFG_IDX_W-1:0]   index;
  logic [rrlp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/read_response_latency_policy.sv
// Top level of the read-response latency policy block.
//
// Each request word on req_i (source id, tag, address, length) yields exactly
// one response word on rsp_o: whether to send a void reply, whether fault
// injection forced it, the reason code, the signed jitter, the completion
// delay and the four saturating statistics counters after this request.
// Configuration is written through cfg_i, which is always ready; registers
// are to be changed only while no request is in flight.
// Requests are taken one at a time. With the policy disabled or a zero
// jitter span the delay is set at acceptance, and the request passes
// through the decide state into the output register. Otherwise the hash
// chain runs five finaliser rounds (a set-up step, then two passes
// through the shared multiplier), then the bit-serial remainder unit runs,
// and the request passes through the decide state; the next request is
// accepted only once it has left the decide state.
// The response sits in an output register: a new request is accepted while
// it waits, but the next response is held back until the receiver takes it.
// Reset clears the counters, the configuration (seed to one) and the channels.
`timescale 1ns / 1ps
`default_nettype none

module read_response_latency_policy (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rrlp_cfg_if.sink     cfg_i,
  rrlp_req_if.sink     req_i,
  rrlp_rsp_if.source   rsp_o
);
  import rrlp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MIX    = 3'd1;
  localparam logic [2:0] S_MUL_A  = 3'd2;
  localparam logic [2:0] S_MUL_B  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  localparam logic [2:0] RND_SRC  = 3'd0;
  localparam logic [2:0] RND_TAG  = 3'd1;
  localparam logic [2:0] RND_ADDR = 3'd2;
  localparam logic [2:0] RND_LEN  = 3'd3;
  localparam logic [2:0] RND_DRAW = 3'd4;

  cfg_t cfg;

  logic [2:0]            state_q, state_d;
  logic [2:0]            round_q, round_d;
  logic [HASH_W-1:0]     key_q, key_d;
  logic [SRC_W-1:0]      src_q;
  logic [TAG_W-1:0]      tag_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [LEN_W-1:0]      len_q;
  logic [DLY_W-1:0]      jit_q, jit_d, dly_q, dly_d;
  logic [COUNT_BITS-1:0] eval_q, norm_q, null_q, fault_q;
  logic [COUNT_BITS-1:0] eval_d, norm_d, null_d, fault_d;

  logic                  out_valid_q;
  logic                  out_send_q, out_forced_q;
  logic [REASON_W-1:0]   out_reason_q;
  logic [DLY_W-1:0]      out_jit_q, out_dly_q;
  logic [STAT_W-1:0]     out_eval_q, out_norm_q, out_null_q, out_fault_q;

  logic                  accept, emit, slot_free;
  logic                  mul_start, mul_done;
  logic [HASH_W-1:0]     mul_a, mul_b, mul_p, fin;
  logic                  div_start, div_done;
  logic [DLY_W-1:0]      div_rem;
  logic [HASH_W-1:0]     word;
  logic [DLY_W+1:0]      sum;
  logic                  forced, over, send;
  logic [REASON_W-1:0]   reason;

  rrlp_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rrlp_mul64 u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  rrlp_divmod u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_d),
    .divisor_i  ({cfg.jitter_span, 1'b1}),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);
  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign emit        = (state_q == S_DECIDE) && slot_free;

  // Word folded into the key in each finaliser round.
  always_comb begin
    case (round_q)
      RND_SRC:  word = HASH_W'(src_q);
      RND_TAG:  word = HASH_W'(tag_q);
      RND_ADDR: word = addr_q;
      RND_LEN:  word = HASH_W'(len_q);
      default:  word = DRAW_LANE;
    endcase
  end

  assign fin       = mul_p ^ (mul_p >> SHIFT_C);
  assign mul_start = (state_q == S_MIX) || ((state_q == S_MUL_A) && mul_done);
  assign mul_a     = (state_q == S_MIX) ? premix(key_q, word) : (mul_p ^ (mul_p >> SHIFT_B));
  assign mul_b     = (state_q == S_MIX) ? MUL_ONE : MUL_TWO;
  assign div_start = (state_q == S_MUL_B) && mul_done && (round_q == RND_DRAW);

  // Delay is latency plus the remainder minus the span, clamped at zero.
  assign sum = {3'b000, cfg.latency} + {2'b00, div_rem} - {3'b000, cfg.jitter_span};

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    key_d   = key_q;
    jit_d   = jit_q;
    dly_d   = dly_q;
    case (state_q)
      S_IDLE: begin
        round_d = RND_SRC;
        key_d   = cfg.seed;
        if (accept) begin
          if (!cfg.enable) begin
            jit_d   = '0;
            dly_d   = '0;
            state_d = S_DECIDE;
          end else if (cfg.jitter_span == '0) begin
            jit_d   = '0;
            dly_d   = {1'b0, cfg.latency};
            state_d = S_DECIDE;
          end else begin
            state_d = S_MIX;
          end
        end
      end
      S_MIX: begin
        state_d = S_MUL_A;
      end
      S_MUL_A: begin
        if (mul_done) begin
          state_d = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (mul_done) begin
          key_d = fin;
          if (round_q == RND_DRAW) begin
            state_d = S_DIV;
          end else begin
            round_d = round_q + 3'd1;
            state_d = S_MIX;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          jit_d   = div_rem - {1'b0, cfg.jitter_span};
          dly_d   = sum[DLY_W+1] ? '0 : sum[DLY_W-1:0];
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Verdict and counter updates; the fault window uses the count before this request.
  always_comb begin
    forced = cfg.enable && (64'(eval_q) < 64'(cfg.forced_void));
    over   = dly_q > {1'b0, cfg.threshold};
    send   = forced || (cfg.enable && over);
    if (!cfg.enable) begin
      reason = REASON_DISABLED;
    end else if (forced) begin
      reason = REASON_FAULT;
    end else if (over) begin
      reason = REASON_OVER;
    end else begin
      reason = REASON_WITHIN;
    end
    eval_d  = sat_inc(eval_q);
    norm_d  = send ? norm_q : sat_inc(norm_q);
    null_d  = send ? sat_inc(null_q) : null_q;
    fault_d = forced ? sat_inc(fault_q) : fault_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= RND_SRC;
      eval_q      <= '0;
      norm_q      <= '0;
      null_q      <= '0;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      if (emit) begin
        eval_q      <= eval_d;
        norm_q      <= norm_d;
        null_q      <= null_d;
        fault_q     <= fault_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    jit_q <= jit_d;
    dly_q <= dly_d;
    if (accept) begin
      src_q  <= req_i.source_id;
      tag_q  <= req_i.request_tag;
      addr_q <= req_i.remote_addr;
      len_q  <= req_i.read_length;
    end
    if (emit) begin
      out_send_q   <= send;
      out_forced_q <= forced;
      out_reason_q <= reason;
      out_jit_q    <= jit_q;
      out_dly_q    <= dly_q;
      out_eval_q   <= STAT_W'(eval_d);
      out_norm_q   <= STAT_W'(norm_d);
      out_null_q   <= STAT_W'(null_d);
      out_fault_q  <= STAT_W'(fault_d);
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.send_null_reply  = out_send_q;
  assign rsp_o.fault_forced     = out_forced_q;
  assign rsp_o.reason_code      = out_reason_q;
  assign rsp_o.jitter_value     = out_jit_q;
  assign rsp_o.completion_delay = out_dly_q;
  assign rsp_o.evaluated_total  = out_eval_q;
  assign rsp_o.normal_total     = out_norm_q;
  assign rsp_o.null_total       = out_null_q;
  assign rsp_o.fault_total      = out_fault_q;

endmodule

`default_nettype wire

>>> hdl/rrlp_regs.sv
// Configuration register file of the policy block.
`timescale 1ns / 1ps
`default_nettype none

module rrlp_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rrlp_cfg_if.sink            cfg_i,
  output rrlp_pkg::cfg_t      cfg_o
);
  import rrlp_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= 1'b0;
      cfg_q.threshold   <= '0;
      cfg_q.latency     <= '0;
      cfg_q.jitter_span <= '0;
      cfg_q.forced_void <= '0;
      cfg_q.seed        <= SEED_RESET;
    end else if (cfg_i.valid) begin
      // The delay registers keep at most 32 bits of the written word.
      case (cfg_i.index)
        CFG_ENABLE:    cfg_q.enable      <= cfg_i.data[0];
        CFG_THRESHOLD: cfg_q.threshold   <= LAT_W'(cfg_i.data[31:0]);
        CFG_LATENCY:   cfg_q.latency     <= LAT_W'(cfg_i.data[31:0]);
        CFG_JITTER:    cfg_q.jitter_span <= LAT_W'(cfg_i.data[31:0]);
        CFG_FORCED:    cfg_q.forced_void <= cfg_i.data[FVC_W-1:0];
        CFG_SEED:      cfg_q.seed        <= cfg_i.data[HASH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/rrlp_mul64.sv
// Shared 64-bit multiplier, low half of the product built from three 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none

module rrlp_mul64 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rrlp_pkg::HASH_W-1:0]   a_i,
  input  wire logic [rrlp_pkg::HASH_W-1:0]   b_i,
  output logic                               done_o,
  output logic [rrlp_pkg::HASH_W-1:0]        prod_o
);
  import rrlp_pkg::*;

  localparam int unsigned HALF = HASH_W / 2;
  localparam logic [1:0] STEP_LO = 2'd0;
  localparam logic [1:0] STEP_AH = 2'd1;
  localparam logic [1:0] STEP_BH = 2'd2;

  logic [HASH_W-1:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]        step_q;
  logic              busy_q, done_q;
  logic [HALF-1:0]   opa, opb;
  logic [HASH_W-1:0] part;

  always_comb begin
    opa  = (step_q == STEP_AH) ? a_q[HASH_W-1:HALF] : a_q[HALF-1:0];
    opb  = (step_q == STEP_BH) ? b_q[HASH_W-1:HALF] : b_q[HALF-1:0];
    part = opa * opb;
    // Cross terms only reach the upper half of the 64-bit result.
    if (step_q == STEP_LO) begin
      acc_d = part;
    end else begin
      acc_d = acc_q + {part[HALF-1:0], {HALF{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LO;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_LO;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == STEP_BH) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> hdl/rrlp_divmod.sv
// Bit-serial restoring remainder unit: 64-bit dividend modulo the jitter width.
`timescale 1ns / 1ps
`default_nettype none

module rrlp_divmod (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [rrlp_pkg::HASH_W-1:0]   dividend_i,
  input  wire logic [rrlp_pkg::DLY_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [rrlp_pkg::DLY_W-1:0]         rem_o
);
  import rrlp_pkg::*;

  localparam int unsigned CNT_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(HASH_W - 1);

  logic [DLY_W-1:0]  rem_q, rem_d, dsr_q;
  logic [HASH_W-1:0] dvd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DLY_W:0]    shifted;
  logic [DLY_W+1:0]  diff;

  always_comb begin
    shifted = {rem_q, dvd_q[HASH_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    // A clear top bit means the shifted remainder reached the divisor.
    if (!diff[DLY_W+1]) begin
      rem_d = diff[DLY_W-1:0];
    end else begin
      rem_d = shifted[DLY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LAST_BIT) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> tb/rrlp_decision_check.sv
// Watches the policy channels, predicts each response word and compares it field by field.
`timescale 1ns / 1ps

module rrlp_decision_check
  import rrlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rrlp_cfg_if         cfg_i,
  rrlp_req_if         req_i,
  rrlp_rsp_if         rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic                  send_null;
    logic                  fault;
    logic [REASON_W-1:0]   reason;
    logic [DLY_W-1:0]      jitter;
    logic [DLY_W-1:0]      delay;
    logic [STAT_W-1:0]     evaluated;
    logic [STAT_W-1:0]     normal;
    logic [STAT_W-1:0]     null_total;
    logic [STAT_W-1:0]     faults;
  } decision_t;

  cfg_t                  policy;
  logic [COUNT_BITS-1:0] seen_cnt;
  logic [COUNT_BITS-1:0] normal_cnt;
  logic [COUNT_BITS-1:0] void_cnt;
  logic [COUNT_BITS-1:0] fault_cnt;
  decision_t             pending_decisions[$];
  int unsigned           words_seen;

  function automatic logic [HASH_W-1:0] splitmix_fold(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] x;
    x = v + GOLDEN_ADD;
    x = (x ^ (x >> SHIFT_A)) * MUL_ONE;
    x = (x ^ (x >> SHIFT_B)) * MUL_TWO;
    return x ^ (x >> SHIFT_C);
  endfunction

  function automatic logic [COUNT_BITS-1:0] saturating_bump(input logic [COUNT_BITS-1:0] c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
  endfunction

  // Works out the response word of one request and advances the statistics.
  function automatic decision_t policy_decision(input logic [SRC_W-1:0]  src,
                                                input logic [TAG_W-1:0]  tag,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [LEN_W-1:0]  len);
    decision_t             d;
    logic [COUNT_BITS-1:0] prior;
    logic [HASH_W-1:0]     key;
    logic [HASH_W-1:0]     span;
    logic [HASH_W-1:0]     lat;
    logic [HASH_W-1:0]     r;
    logic [HASH_W-1:0]     below;
    logic [HASH_W-1:0]     jitter;
    logic [HASH_W-1:0]     delay;
    d      = '0;
    jitter = '0;
    delay  = '0;
    prior  = seen_cnt;
    seen_cnt = saturating_bump(seen_cnt);
    if (!policy.enable) begin
      d.reason   = REASON_DISABLED;
      normal_cnt = saturating_bump(normal_cnt);
    end else begin
      span = HASH_W'(policy.jitter_span);
      lat  = HASH_W'(policy.latency);
      if (span != '0) begin
        key = splitmix_fold(policy.seed ^ HASH_W'(src));
        key = splitmix_fold(key ^ HASH_W'(tag));
        key = splitmix_fold(key ^ addr);
        key = splitmix_fold(key ^ HASH_W'(len));
        r   = splitmix_fold(key ^ DRAW_LANE) % ((span << 1) + 64'd1);
        // Negative jitter wraps to two's complement and is cut to the port width.
        jitter = r - span;
        if (r >= span) begin
          delay = lat + (r - span);
        end else begin
          below = span - r;
          delay = (below > lat) ? '0 : lat - below;
        end
      end else begin
        delay = lat;
      end
      // The fault window looks at the count before this request.
      if (HASH_W'(prior) < HASH_W'(policy.forced_void)) begin
        d.send_null = 1'b1;
        d.fault     = 1'b1;
        d.reason    = REASON_FAULT;
        fault_cnt   = saturating_bump(fault_cnt);
      end else if (delay > HASH_W'(policy.threshold)) begin
        d.send_null = 1'b1;
        d.reason    = REASON_OVER;
      end else begin
        d.reason = REASON_WITHIN;
      end
      if (d.send_null) begin
        void_cnt = saturating_bump(void_cnt);
      end else begin
        normal_cnt = saturating_bump(normal_cnt);
      end
    end
    d.jitter     = jitter[DLY_W-1:0];
    d.delay      = delay[DLY_W-1:0];
    d.evaluated  = STAT_W'(seen_cnt);
    d.normal     = STAT_W'(normal_cnt);
    d.null_total = STAT_W'(void_cnt);
    d.faults     = STAT_W'(fault_cnt);
    return d;
  endfunction

  task automatic flag_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10) begin
        $display("%0t: word %0d, %s: expected %0h, got %0h",
                 $time, words_seen, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    if (!rst_ni) begin
      policy.enable      = 1'b0;
      policy.threshold   = '0;
      policy.latency     = '0;
      policy.jitter_span = '0;
      policy.forced_void = '0;
      policy.seed        = SEED_RESET;
      seen_cnt           = '0;
      normal_cnt         = '0;
      void_cnt           = '0;
      fault_cnt          = '0;
      words_seen         = 0;
      mismatch_count_o   = 0;
      outstanding_o      = 0;
      pending_decisions.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ENABLE:    policy.enable      = cfg_i.data[0];
          CFG_THRESHOLD: policy.threshold   = cfg_i.data[LAT_W-1:0];
          CFG_LATENCY:   policy.latency     = cfg_i.data[LAT_W-1:0];
          CFG_JITTER:    policy.jitter_span = cfg_i.data[LAT_W-1:0];
          CFG_FORCED:    policy.forced_void = cfg_i.data[FVC_W-1:0];
          CFG_SEED:      policy.seed        = cfg_i.data[HASH_W-1:0];
          default: ;
        endcase
      end
      // A word leaving at this edge belongs to an older request than one entering.
      if (rsp_i.valid && rsp_i.ready) begin
        words_seen++;
        if (pending_decisions.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: word %0d arrived with no request outstanding", $time, words_seen);
          end
        end else begin
          want = pending_decisions.pop_front();
          flag_field("send_null_reply", 64'(want.send_null), 64'(rsp_i.send_null_reply));
          flag_field("fault_forced", 64'(want.fault), 64'(rsp_i.fault_forced));
          flag_field("reason_code", 64'(want.reason), 64'(rsp_i.reason_code));
          flag_field("jitter_value", 64'(want.jitter), 64'($unsigned(rsp_i.jitter_value)));
          flag_field("completion_delay", 64'(want.delay), 64'(rsp_i.completion_delay));
          flag_field("evaluated_total", 64'(want.evaluated), 64'(rsp_i.evaluated_total));
          flag_field("normal_total", 64'(want.normal), 64'(rsp_i.normal_total));
          flag_field("null_total", 64'(want.null_total), 64'(rsp_i.null_total));
          flag_field("fault_total", 64'(want.faults), 64'(rsp_i.fault_total));
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_decisions.push_back(policy_decision(req_i.source_id, req_i.request_tag,
                                                    req_i.remote_addr, req_i.read_length));
      end
      outstanding_o = pending_decisions.size();
    end
  end

endmodule

>>> tb/read_response_latency_policy_test.sv
// Stimulus, handshake pacing and verdict for the read-response latency policy block.
`timescale 1ns / 1ps

module read_response_latency_policy_test;
  import rrlp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 150;
  localparam logic [31:0] NS_MAX      = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          no_idle = 1'b0;
  int unsigned items_sent = 0;
  int unsigned mismatches;
  int unsigned outstanding;

  rrlp_cfg_if cfg ();
  rrlp_req_if req ();
  rrlp_rsp_if rsp ();

  read_response_latency_policy uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  rrlp_decision_check u_decision_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_i            (cfg),
    .req_i            (req),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] rand_ns();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'($urandom_range(2, 300));
      3:       return 32'($urandom_range(301, 2000000));
      4:       return $urandom();
      default: return NS_MAX;
    endcase
  endfunction

  // Valid is left high after a word is taken so that back-to-back words need no second edit.
  task automatic send_request(input logic [SRC_W-1:0] src, input logic [TAG_W-1:0] tag,
                              input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.source_id   <= src;
    req.request_tag <= tag;
    req.remote_addr <= addr;
    req.read_length <= len;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  task automatic send_random();
    send_request(SRC_W'($urandom()), $urandom(), {$urandom(), $urandom()}, $urandom());
  endtask

  // Stops offering and waits until every outstanding response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic program_policy(input bit en, input logic [31:0] thr, input logic [31:0] lat,
                                input logic [31:0] span, input logic [31:0] fvc,
                                input logic [63:0] seed);
    reg_write(CFG_ENABLE, CFG_DATA_W'(en));
    reg_write(CFG_THRESHOLD, CFG_DATA_W'(thr));
    reg_write(CFG_LATENCY, CFG_DATA_W'(lat));
    reg_write(CFG_JITTER, CFG_DATA_W'(span));
    reg_write(CFG_FORCED, CFG_DATA_W'(fvc));
    reg_write(CFG_SEED, seed);
    cfg.valid <= 1'b0;
  endtask

  // Response side: random back-pressure, plus one long hold-off while requests keep coming.
  initial begin
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    rsp.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) taken++;
      if (!held && taken >= 150 && req.valid) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp.ready <= no_idle || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("read_response_latency_policy_test failed");
    $finish;
  end

  initial begin
    logic [31:0] lat;
    logic [31:0] span;
    logic [31:0] thr;
    logic [31:0] fvc;
    logic [63:0] seed;
    rst_n           <= 1'b0;
    req.valid       <= 1'b0;
    req.source_id   <= '0;
    req.request_tag <= '0;
    req.remote_addr <= '0;
    req.read_length <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= CFG_ENABLE;
    cfg.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: policy disabled, every word normal.
    send_request('0, '0, '0, '0);
    send_request('1, '1, '1, '1);
    send_random();
    drain();

    // Zero seed, zero span: the first two requests fall in the fault window.
    program_policy(1'b1, 32'd100, 32'd50, 32'd0, items_sent + 2, 64'd0);
    repeat (4) send_random();
    drain();

    program_policy(1'b1, 32'd60, 32'd80, 32'd0, 32'd0, 64'd1);
    repeat (2) send_random();
    drain();

    // Span far above latency, so negative jitter clamps the delay to zero.
    program_policy(1'b1, 32'd5, 32'd10, 32'd1000, 32'd0, {$urandom(), $urandom()});
    repeat (5) send_random();
    drain();

    program_policy(1'b1, NS_MAX, NS_MAX, NS_MAX, 32'd0, '1);
    send_request('0, '0, '0, '0);
    send_request('1, '1, '1, '1);
    send_random();
    drain();

    // Widest fault window: everything is forced void.
    program_policy(1'b1, 32'd0, 32'd0, 32'd1, NS_MAX, {$urandom(), $urandom()});
    repeat (3) send_random();
    drain();

    program_policy(1'b1, 32'd0, NS_MAX, NS_MAX, 32'd0, 64'd0);
    send_request('1, '1, '1, '1);
    send_request('0, '0, '0, '0);
    send_random();
    drain();

    for (int p = 0; p < 8; p++) begin
      lat  = rand_ns();
      span = rand_ns();
      if ($urandom_range(0, 3) != 0 && span > lat) span = lat;
      thr  = ($urandom_range(0, 1) == 0) ? lat : rand_ns();
      fvc  = ($urandom_range(0, 1) == 0) ? items_sent + $urandom_range(0, 3) : 32'd0;
      seed = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom(), $urandom()};
      program_policy(p != 3, thr, lat, span, fvc, seed);
      no_idle = (p == 1);
      repeat (90) send_random();
      drain();
    end
    no_idle = 1'b0;

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("read_response_latency_policy_test passed");
    end else begin
      $display("read_response_latency_policy_test failed");
    end
    $finish;
  end

endmodule
